// ----- rtl/ksm_pkg.sv -----
// shared constants, types and codes for the key scan to midi note event block
`default_nettype none

package ksm_pkg;

    // keyboard geometry
    localparam int KEY_COUNT   = 16;
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_COUNT = (KEY_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W       = GROUP_COUNT * GROUP_SIZE;
    localparam int KEY_W       = $clog2(PAD_W);
    localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int SLOT_W      = $clog2(GROUP_SIZE);
    localparam int PASS_W      = GRP_W + 1;

    // stream widths
    localparam int S_TDATA_W = ((KEY_COUNT + 7) / 8) * 8;
    localparam int BYTE_W    = 8;
    localparam int NOTE_W    = 7;

    // midi status bytes
    localparam logic [BYTE_W-1:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;

    // register reset values
    localparam logic [NOTE_W-1:0] RESET_BASE_NOTE = 7'h18;
    localparam logic [NOTE_W-1:0] RESET_VELOCITY  = 7'h7F;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_NOTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY  = 1'b1;

    // search kind carried in the low bit of the pass counter
    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result of the shared search / note unit
    typedef struct packed {
        logic              found;
        logic [KEY_W-1:0]  key;
        logic [NOTE_W-1:0] note;
    } ksm_hit_t;

endpackage

`default_nettype wire

// ----- rtl/ksm_unit.sv -----
// shared search unit: lowest pending key of one group and its note number
`default_nettype none

module ksm_unit
(
    input  wire logic [ksm_pkg::GROUP_SIZE-1:0] grp_mask,
    input  wire logic [ksm_pkg::GRP_W-1:0]      grp,
    input  wire logic [ksm_pkg::NOTE_W-1:0]     base_note,
    output ksm_pkg::ksm_hit_t                   hit
);

    logic [ksm_pkg::SLOT_W-1:0] slot;
    logic [ksm_pkg::KEY_W-1:0]  key;

    // priority pick, lowest key wins
    always_comb
    begin
        slot = '0;
        for (int i = ksm_pkg::GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (grp_mask[i])
            begin
                slot = ksm_pkg::SLOT_W'(i);
            end
        end
    end

    assign key = ksm_pkg::KEY_W'({grp, slot});

    // note wraps modulo 128
    always_comb
    begin
        hit.found = |grp_mask;
        hit.key   = key;
        hit.note  = ksm_pkg::NOTE_W'(base_note
                    + {{(ksm_pkg::NOTE_W - ksm_pkg::KEY_W){1'b0}}, key});
    end

endmodule

`default_nettype wire

// ----- rtl/ksm_ctrl.sv -----
// sequencer: scan compare, pending key masks, byte emission and output register
`default_nettype none

module ksm_ctrl
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ksm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ksm_pkg::BYTE_W-1:0]           m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [ksm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ksm_pkg::NOTE_W-1:0]      cfg_data,
    output logic [ksm_pkg::GROUP_SIZE-1:0]       grp_mask,
    output logic [ksm_pkg::GRP_W-1:0]            grp,
    output logic [ksm_pkg::NOTE_W-1:0]           base_note,
    input  wire ksm_pkg::ksm_hit_t               hit
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_NOTE,
        ST_VEL
    } state_t;

    state_t                         state_reg, state_next;
    logic [ksm_pkg::KEY_COUNT-1:0]  prev_reg, prev_next;
    logic [ksm_pkg::PAD_W-1:0]      pressed_reg, pressed_next;
    logic [ksm_pkg::PAD_W-1:0]      released_reg, released_next;
    logic [ksm_pkg::PASS_W-1:0]     pass_reg, pass_next;
    logic [ksm_pkg::NOTE_W-1:0]     note_reg, note_next;
    logic [ksm_pkg::NOTE_W-1:0]     base_reg, base_next;
    logic [ksm_pkg::NOTE_W-1:0]     vel_reg, vel_next;
    logic                           m_valid_reg, m_valid_next;
    logic [ksm_pkg::BYTE_W-1:0]     m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    logic                           kind;
    logic [ksm_pkg::PAD_W-1:0]      src;
    logic                           out_free;
    logic                           load;
    logic [ksm_pkg::BYTE_W-1:0]     load_byte;
    logic                           load_last;
    logic [ksm_pkg::KEY_COUNT-1:0]  now;
    logic [ksm_pkg::KEY_COUNT-1:0]  changed;

    assign kind     = pass_reg[0];
    assign grp      = pass_reg[ksm_pkg::PASS_W-1:1];
    assign src      = (kind == ksm_pkg::KIND_RELEASE) ? released_reg : pressed_reg;
    assign grp_mask = src[grp * ksm_pkg::GROUP_SIZE +: ksm_pkg::GROUP_SIZE];
    assign base_note = base_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign now      = s_tdata[ksm_pkg::KEY_COUNT-1:0];
    assign changed  = now ^ prev_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        prev_next     = prev_reg;
        pressed_next  = pressed_reg;
        released_next = released_reg;
        pass_next     = pass_reg;
        note_next     = note_reg;
        base_next     = base_reg;
        vel_next      = vel_reg;
        load          = 1'b0;
        load_byte     = '0;
        load_last     = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                ksm_pkg::CFG_BASE_NOTE: base_next = cfg_data;
                ksm_pkg::CFG_VELOCITY:  vel_next  = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    prev_next     = now;
                    pressed_next  = ksm_pkg::PAD_W'(~now & changed);
                    released_next = ksm_pkg::PAD_W'(now & changed);
                    pass_next     = '0;
                    if (|changed)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit.found)
                begin
                    if (out_free)
                    begin
                        load      = 1'b1;
                        load_byte = (kind == ksm_pkg::KIND_RELEASE) ?
                                    ksm_pkg::STATUS_NOTE_OFF : ksm_pkg::STATUS_NOTE_ON;
                        note_next = hit.note;
                        if (kind == ksm_pkg::KIND_RELEASE)
                        begin
                            released_next[hit.key] = 1'b0;
                        end
                        else
                        begin
                            pressed_next[hit.key] = 1'b0;
                        end
                        state_next = ST_NOTE;
                    end
                end
                else
                begin
                    pass_next = ksm_pkg::PASS_W'(pass_reg + 1'b1);
                end
            end
            ST_NOTE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_byte  = {1'b0, note_reg};
                    state_next = ST_VEL;
                end
            end
            ST_VEL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_byte  = {1'b0, vel_reg};
                    load_last  = ~|(pressed_reg | released_reg);
                    state_next = load_last ? ST_IDLE : ST_SEARCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = load_byte;
            m_last_next  = load_last;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            pressed_reg  <= '0;
            released_reg <= '0;
            pass_reg     <= '0;
            note_reg     <= '0;
            base_reg     <= ksm_pkg::RESET_BASE_NOTE;
            vel_reg      <= ksm_pkg::RESET_VELOCITY;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_reg     <= prev_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            pass_reg     <= pass_next;
            note_reg     <= note_next;
            base_reg     <= base_next;
            vel_reg      <= vel_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
            m_last_reg   <= m_last_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/key_scan_midi_note_events_top.sv -----
// top level of the key scan to midi note event block
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------------
//  s_*      | in        | s_tvalid / s_tready | s_tdata[15:0] = scan_bits (active low)
//  m_*      | out       | m_tvalid / m_tready | m_tdata[7:0] = midi_byte, m_tlast = last
//  cfg_*    | in        | cfg_we              | cfg_index (0 base_note, 1 velocity), cfg_data
//
// a scan beat is taken only while the sequencer is idle; an unchanged scan leaves it idle, and
// each note message is a status, note and velocity byte (one byte per cycle out of the output
// register while m_tready holds); an empty group pass between messages emits no byte
// unstalled, the sequencer's one-byte-per-cycle emission through the output register sets the rate
// after reset the previous scan is all zeros, base note 24, velocity 127
// a stalled m_tready holds the current byte and stops the sequencer before its next byte load

`default_nettype none

module key_scan_midi_note_events_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // scan beat input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ksm_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] scan_bits
    // midi byte output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ksm_pkg::BYTE_W-1:0]           m_tdata,   // [7:0] midi_byte
    output logic                                 m_tlast,   // last byte of this scan
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [ksm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ksm_pkg::NOTE_W-1:0]      cfg_data
);

    logic [ksm_pkg::GROUP_SIZE-1:0] grp_mask;
    logic [ksm_pkg::GRP_W-1:0]      grp;
    logic [ksm_pkg::NOTE_W-1:0]     base_note;
    ksm_pkg::ksm_hit_t              hit;

    // sequencer walks group passes: presses then releases for each group of eight
    ksm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grp_mask  (grp_mask),
        .grp       (grp),
        .base_note (base_note),
        .hit       (hit)
    );

    // shared unit: finds the next pending key of the current pass and its note
    ksm_unit u_unit
    (
        .grp_mask  (grp_mask),
        .grp       (grp),
        .base_note (base_note),
        .hit       (hit)
    );

endmodule

`default_nettype wire

// ----- rtl/ksm_checker.sv -----
// port-level checker for the key scan to midi note event block, with its bind
`default_nettype none

module ksm_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [ksm_pkg::BYTE_W-1:0]      m_tdata,
    input  wire logic                            m_tlast
);

    // a stalled output beat holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // the last byte of a run is always a velocity data byte
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[7])
        else $error("last flag on a status byte");

    // once a status byte leaves, the rest of its message is still owed
    a_busy_mid_msg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[7] |=> !s_tready)
        else $error("scan input ready in the middle of a message");

    // a new scan is never taken in the middle of a message
    a_status_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[7] |=> !(s_tvalid && s_tready))
        else $error("scan beat taken before message completed");

endmodule

bind key_scan_midi_note_events_top ksm_checker u_ksm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- sim/ksm_note_checker.sv -----
`timescale 1ns / 100ps
// watches the scan and midi channels, predicts the note bytes and compares them

module ksm_note_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ksm_pkg::S_TDATA_W-1:0]       s_tdata,   // [15:0] scan_bits
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ksm_pkg::BYTE_W-1:0]          m_tdata,   // [7:0] midi_byte
    input  logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [ksm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ksm_pkg::NOTE_W-1:0]          cfg_data,
    output int                                  errors,
    output int                                  pending,
    output int                                  scans_seen,
    output int                                  bytes_seen
);

    typedef struct packed {
        logic [ksm_pkg::BYTE_W-1:0] midi_byte;
        logic                       last_byte;
    } midi_beat_t;

    midi_beat_t                      note_bytes_due[$];
    midi_beat_t                      beat_due;
    logic [ksm_pkg::KEY_COUNT-1:0]   prev_scan;
    logic [ksm_pkg::NOTE_W-1:0]      base_note;
    logic [ksm_pkg::NOTE_W-1:0]      velocity;

    // per group: presses then releases, ascending key, last flag on the final byte
    task automatic queue_note_messages(input logic [ksm_pkg::KEY_COUNT-1:0] scan);
        logic [ksm_pkg::KEY_COUNT-1:0] changed;
        logic [ksm_pkg::KEY_COUNT-1:0] pressed;
        logic [ksm_pkg::KEY_COUNT-1:0] released;
        logic [ksm_pkg::BYTE_W-1:0]    msg [3];
        logic                          kind;
        logic                          hit;
        int                            total;
        int                            emitted;
        int                            key;
        changed  = scan ^ prev_scan;
        pressed  = ~scan & changed;
        released = ~prev_scan & changed;
        total    = 3 * ($countones(pressed) + $countones(released));
        emitted  = 0;
        for (int grp = 0; grp < ksm_pkg::GROUP_COUNT; grp++) begin
            for (int k = 0; k < 2; k++) begin
                kind = (k == 0) ? ksm_pkg::KIND_PRESS : ksm_pkg::KIND_RELEASE;
                for (int slot = 0; slot < ksm_pkg::GROUP_SIZE; slot++) begin
                    key = grp * ksm_pkg::GROUP_SIZE + slot;
                    if (key < ksm_pkg::KEY_COUNT) begin
                        hit = (kind == ksm_pkg::KIND_PRESS) ? pressed[key] : released[key];
                        if (hit) begin
                            msg[0] = (kind == ksm_pkg::KIND_PRESS) ? ksm_pkg::STATUS_NOTE_ON
                                                                    : ksm_pkg::STATUS_NOTE_OFF;
                            // note wraps in seven bits
                            msg[1] = {1'b0, 7'(base_note + 7'(key))};
                            msg[2] = {1'b0, velocity};
                            for (int b = 0; b < 3; b++) begin
                                note_bytes_due.push_back('{msg[b], emitted == total - 1});
                                emitted++;
                            end
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_scan  = '0;
            base_note  = ksm_pkg::RESET_BASE_NOTE;
            velocity   = ksm_pkg::RESET_VELOCITY;
            note_bytes_due.delete();
            errors     = 0;
            pending    = 0;
            scans_seen = 0;
            bytes_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                bytes_seen++;
                if (note_bytes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected midi beat, expected none, actual byte %02h last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    beat_due = note_bytes_due.pop_front();
                    if (m_tdata !== beat_due.midi_byte)
                    begin
                        errors++;
                        $display("%0t: midi_byte mismatch, expected %02h, actual %02h",
                                 $time, beat_due.midi_byte, m_tdata);
                    end
                    if (m_tlast !== beat_due.last_byte)
                    begin
                        errors++;
                        $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                                 $time, beat_due.last_byte, m_tlast);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ksm_pkg::CFG_BASE_NOTE: base_note = cfg_data;
                    ksm_pkg::CFG_VELOCITY:  velocity  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                queue_note_messages(s_tdata[ksm_pkg::KEY_COUNT-1:0]);
                prev_scan = s_tdata[ksm_pkg::KEY_COUNT-1:0];
                scans_seen++;
            end
            pending = note_bytes_due.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top: scan stimulus, receiver stalls, voicing changes and the verdict

module tb_top;

    // timing of the run
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;      // long receiver hold-off
    localparam int CYCLE_LIMIT   = 4000000;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [ksm_pkg::S_TDATA_W-1:0]     s_tdata;     // [15:0] scan_bits
    logic                              m_tvalid;
    logic                              m_tready;
    logic [ksm_pkg::BYTE_W-1:0]        m_tdata;     // [7:0] midi_byte
    logic                              m_tlast;     // last byte of the scan
    logic                              cfg_we;
    logic [ksm_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [ksm_pkg::NOTE_W-1:0]        cfg_data;

    int                                chk_errors;
    int                                chk_pending;
    int                                scans_seen;
    int                                bytes_seen;
    int                                cycle_count = 0;

    // flags shared between the sender and the receiver process, and the sender's last scan
    logic                              quiet;       // no gaps on either side
    logic                              hold_req;    // ask the receiver for a long hold-off
    logic [ksm_pkg::KEY_COUNT-1:0]     scan_now;    // last scan word taken

    key_scan_midi_note_events_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ksm_note_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (chk_errors),
        .pending    (chk_pending),
        .scans_seen (scans_seen),
        .bytes_seen (bytes_seen)
    );

    // 4 ns clock
    always #2 clk = ~clk;

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // gap length in cycles: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        else if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(15, 40);
    endfunction

    // next scan word: mostly a few keys moving, some unchanged scans,
    // some whole-keyboard noise and some one-group chords
    function automatic logic [ksm_pkg::KEY_COUNT-1:0] next_scan(
        input logic [ksm_pkg::KEY_COUNT-1:0] prev);
        logic [ksm_pkg::KEY_COUNT-1:0] v;
        int                            r;
        int                            flips;
        int                            idx;
        r = $urandom_range(0, 99);
        v = prev;
        if (r < 55)
        begin
            flips = $urandom_range(1, 3);
            for (int f = 0; f < flips; f++)
            begin
                idx    = $urandom_range(0, ksm_pkg::KEY_COUNT - 1);
                v[idx] = ~v[idx];
            end
        end
        else if (r < 70)
            v = prev;
        else if (r < 88)
            v = ksm_pkg::KEY_COUNT'($urandom);
        else if (r < 94)
            v = prev ^ {8'h00, 8'($urandom)};
        else
            v = prev ^ {8'($urandom), 8'h00};
        return v;
    endfunction

    // offer one scan beat and wait for it to be taken; valid stays high
    // across back-to-back beats
    task automatic send_scan(input logic [ksm_pkg::KEY_COUNT-1:0] scan);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= ksm_pkg::S_TDATA_W'(scan);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        scan_now = scan;
        @(negedge clk);
    endtask

    // random scans; the long receiver hold-off starts at beat hold_at
    task automatic run_scans(input int count, input int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            send_scan(next_scan(scan_now));
        end
    endtask

    // stop offering, wait for every expected byte, then let the block go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // both registers, only while the block is idle
    task automatic set_voicing(input logic [ksm_pkg::NOTE_W-1:0] base,
                               input logic [ksm_pkg::NOTE_W-1:0] vel);
        cfg_we    <= 1'b1;
        cfg_index <= ksm_pkg::CFG_BASE_NOTE;
        cfg_data  <= base;
        @(negedge clk);
        cfg_index <= ksm_pkg::CFG_VELOCITY;
        cfg_data  <= vel;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: random stalls, plus the long hold-off when asked
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // sender keeps offering, so the block fills and stalls its input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = ksm_pkg::CFG_BASE_NOTE;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        scan_now  = '0;
        rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset voicing, directed scans
        send_scan(16'hFFFF);    // first scan after reset: every key released
        send_scan(16'hFFFF);    // unchanged scan, no bytes
        send_scan(16'h0000);    // every key pressed
        send_scan(16'h0000);
        send_scan(16'hFFFE);    // keys 1..15 released
        send_scan(16'h7FFE);    // top key pressed
        send_scan(16'hFFFF);    // bottom and top key released
        send_scan(16'hFF00);    // low group pressed
        send_scan(16'h00FF);    // high group pressed, low group released
        send_scan(16'hA55A);    // presses in the low group, releases in the high group
        send_scan(16'h5AA5);
        send_scan(16'hFFFF);
        send_scan(16'hFFEF);
        send_scan(16'hFFFF);
        run_scans(45, -1);
        drain();

        // lowest note and velocity, no idling on either side
        quiet = 1'b1;
        set_voicing(7'd0, 7'd0);
        send_scan(16'h0000);
        send_scan(16'hFFFF);
        run_scans(50, -1);
        drain();
        quiet = 1'b0;

        // highest base note in range, full velocity, with the long hold-off
        set_voicing(7'd112, 7'd127);
        run_scans(60, 8);
        drain();

        // note number wraps past 127
        set_voicing(7'd127, 7'd1);
        send_scan(16'h0000);
        send_scan(16'hFFFF);
        run_scans(50, -1);
        drain();

        // arbitrary voicing
        set_voicing(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        run_scans(50, -1);
        drain();

        set_voicing(7'd120, 7'd64);
        run_scans(55, -1);
        drain();

        $display("tb_top: %0d scan beats and %0d midi beats checked over six voicings,",
                 scans_seen, bytes_seen);
        $display("tb_top: including note wrap, unchanged scans and a long output stall");
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
